// ----- rtl/core/pdp_pkg.sv -----
// Shared types, widths and constants of the point-to-pixel projection block.
`default_nettype none

package pdp_pkg;

   // Camera-frame coordinate width (signed Q20.16 after rotation and shift)
   localparam int CW = 36;
   // Magnitude of a positive camera z
   localparam int ZW = 35;
   // Divider numerator width: |coord| << 16
   localparam int NW = 52;
   // Quotient width
   localparam int QW = 32;
   // Pixel coordinate width in Q12.16 once inside a 4096-wide image
   localparam int PW = 28;

   localparam int DEF_IMAGE_WIDTH  = 640;
   localparam int DEF_IMAGE_HEIGHT = 480;

   // Register reset values: identity rotation
   localparam logic [62:0] ROT_X_RESET = 63'h2000_0000_0000_0000;
   localparam logic [62:0] ROT_Y_RESET = 63'h0000_0100_0000_0000;
   localparam logic [62:0] ROT_Z_RESET = 63'h0000_0000_0008_0000;

   typedef enum logic [1:0] {
      OUT_HIT          = 2'd0,
      OUT_BEHIND       = 2'd1,
      OUT_OUTSIDE_PRE  = 2'd2,
      OUT_OUTSIDE_POST = 2'd3
   } pdp_outcome_type;

   typedef enum logic [2:0] {
      CSR_ROT_X    = 3'd0,
      CSR_ROT_Y    = 3'd1,
      CSR_ROT_Z    = 3'd2,
      CSR_SHIFT_XY = 3'd3,
      CSR_SHIFT_Z  = 3'd4,
      CSR_FOCAL    = 3'd5,
      CSR_CENTER   = 3'd6,
      CSR_RADIAL   = 3'd7
   } pdp_csr_type;

   // Sideband carried through the divider
   typedef struct packed {
      logic                  behind;
      logic signed [CW-1:0]  z;
   } pdp_side_type;

   // Sideband carried through the distortion pipeline
   typedef struct packed {
      pdp_outcome_type  outcome;
      logic [PW-1:0]    u;
      logic [PW-1:0]    v;
      logic [31:0]      r2;
      logic [30:0]      depth;
   } pdp_dist_type;

endpackage

`default_nettype wire

// ----- rtl/core/pdp_transform.sv -----
// Rotation and translation of a world point into the camera frame (two stages).
`default_nettype none

module pdp_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [31:0]                px,
   input  logic signed [31:0]                py,
   input  logic signed [31:0]                pz,
   input  logic [62:0]                       rot_x,
   input  logic [62:0]                       rot_y,
   input  logic [62:0]                       rot_z,
   input  logic [63:0]                       shift_xy,
   input  logic signed [31:0]                shift_z,
   output logic                              out_valid,
   output logic signed [pdp_pkg::CW-1:0]     cam_x,
   output logic signed [pdp_pkg::CW-1:0]     cam_y,
   output logic signed [pdp_pkg::CW-1:0]     cam_z
);

   logic                 v1_ff;
   logic signed [52:0]   prod_ff [0:8];
   logic signed [52:0]   prod_in [0:8];
   logic                 v2_ff;
   logic signed [pdp_pkg::CW-1:0] cam_ff [0:2];
   logic signed [pdp_pkg::CW-1:0] cam_in [0:2];
   logic [62:0]          rows [0:2];
   logic signed [31:0]   pts [0:2];
   logic signed [31:0]   shifts [0:2];

   assign rows[0]   = rot_x;
   assign rows[1]   = rot_y;
   assign rows[2]   = rot_z;
   assign pts[0]    = px;
   assign pts[1]    = py;
   assign pts[2]    = pz;
   assign shifts[0] = signed'(shift_xy[63:32]);
   assign shifts[1] = signed'(shift_xy[31:0]);
   assign shifts[2] = shift_z;

   // Stage 1: nine Q2.19 x Q16.16 products
   always_comb begin
      logic signed [20:0] entry;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            entry = signed'(rows[r][62-21*c -: 21]);
            prod_in[3*r+c] = 53'(entry) * 53'(pts[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: row sums, floor by 2^19, add translation
   always_comb begin
      logic signed [54:0] sum;
      for (int r = 0; r < 3; r++) begin
         sum = 55'(prod_ff[3*r]) + 55'(prod_ff[3*r+1]) + 55'(prod_ff[3*r+2]);
         cam_in[r] = signed'(sum[54:19]) + pdp_pkg::CW'(shifts[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         cam_ff <= cam_in;
      end
   end

   assign out_valid = v2_ff;
   assign cam_x     = cam_ff[0];
   assign cam_y     = cam_ff[1];
   assign cam_z     = cam_ff[2];

endmodule

`default_nettype wire

// ----- rtl/core/pdp_divider.sv -----
// Pipelined restoring divider: x/z and y/z in Q16.16, one quotient bit per stage.
`default_nettype none

module pdp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [pdp_pkg::CW-1:0]     cam_x,
   input  logic signed [pdp_pkg::CW-1:0]     cam_y,
   input  logic signed [pdp_pkg::CW-1:0]     cam_z,
   output logic                              out_valid,
   output logic signed [31:0]                tx,
   output logic signed [31:0]                ty,
   output pdp_pkg::pdp_side_type             out_side
);

   localparam int NW = pdp_pkg::NW;
   localparam int ZW = pdp_pkg::ZW;
   localparam int QW = pdp_pkg::QW;
   localparam int DW = ZW + QW;   // width of a shifted divisor

   logic                  val_ff  [0:QW];
   logic [NW-1:0]         remx_ff [0:QW];
   logic [NW-1:0]         remy_ff [0:QW];
   logic [QW-1:0]         qx_ff   [0:QW];
   logic [QW-1:0]         qy_ff   [0:QW];
   logic                  negx_ff [0:QW];
   logic                  negy_ff [0:QW];
   logic                  ovfx_ff [0:QW];
   logic                  ovfy_ff [0:QW];
   logic [ZW-1:0]         zm_ff   [0:QW];
   pdp_pkg::pdp_side_type side_ff [0:QW];

   logic [pdp_pkg::CW-1:0] xmag;
   logic [pdp_pkg::CW-1:0] ymag;
   logic [NW-1:0]          nx;
   logic [NW-1:0]          ny;
   logic [DW-1:0]          zlim;

   // Entry stage: magnitudes, signs and quotient overflow
   assign xmag = cam_x[pdp_pkg::CW-1] ? pdp_pkg::CW'(-cam_x) : cam_x;
   assign ymag = cam_y[pdp_pkg::CW-1] ? pdp_pkg::CW'(-cam_y) : cam_y;
   assign nx   = {xmag, 16'b0};
   assign ny   = {ymag, 16'b0};
   assign zlim = {cam_z[ZW-1:0], {QW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
      if (adv) begin
         remx_ff[0]        <= nx;
         remy_ff[0]        <= ny;
         qx_ff[0]          <= '0;
         qy_ff[0]          <= '0;
         negx_ff[0]        <= cam_x[pdp_pkg::CW-1];
         negy_ff[0]        <= cam_y[pdp_pkg::CW-1];
         ovfx_ff[0]        <= DW'(nx) >= zlim;
         ovfy_ff[0]        <= DW'(ny) >= zlim;
         zm_ff[0]          <= cam_z[ZW-1:0];
         side_ff[0].behind <= (cam_z <= 0);
         side_ff[0].z      <= cam_z;
      end
   end

   // Quotient bit stages, most significant bit first
   for (genvar s = 1; s <= QW; s++) begin : g_bit
      localparam int B = QW - s;
      logic [DW-1:0] dsh;
      logic          gex;
      logic          gey;

      assign dsh = DW'(zm_ff[s-1]) << B;
      assign gex = DW'(remx_ff[s-1]) >= dsh;
      assign gey = DW'(remy_ff[s-1]) >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else if (adv) begin
            val_ff[s] <= val_ff[s-1];
         end
         if (adv) begin
            remx_ff[s] <= gex ? NW'(DW'(remx_ff[s-1]) - dsh) : remx_ff[s-1];
            remy_ff[s] <= gey ? NW'(DW'(remy_ff[s-1]) - dsh) : remy_ff[s-1];
            qx_ff[s]   <= {qx_ff[s-1][QW-2:0], gex};
            qy_ff[s]   <= {qy_ff[s-1][QW-2:0], gey};
            negx_ff[s] <= negx_ff[s-1];
            negy_ff[s] <= negy_ff[s-1];
            ovfx_ff[s] <= ovfx_ff[s-1];
            ovfy_ff[s] <= ovfy_ff[s-1];
            zm_ff[s]   <= zm_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Output stage: apply sign and saturate to 32 bits
   function automatic logic signed [31:0] sat_ratio(input logic neg, input logic ovf,
                                                     input logic [QW-1:0] q);
      logic signed [31:0] r;
      if (neg) begin
         if (ovf || (q > 32'h8000_0000)) r = 32'sh8000_0000;
         else                            r = signed'(32'(-q));
      end else begin
         if (ovf || q[QW-1]) r = 32'sh7FFF_FFFF;
         else                r = signed'(q);
      end
      return r;
   endfunction

   logic                  vo_ff;
   logic signed [31:0]    tx_ff;
   logic signed [31:0]    ty_ff;
   pdp_pkg::pdp_side_type so_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= val_ff[QW];
      end
      if (adv) begin
         tx_ff <= sat_ratio(negx_ff[QW], ovfx_ff[QW], qx_ff[QW]);
         ty_ff <= sat_ratio(negy_ff[QW], ovfy_ff[QW], qy_ff[QW]);
         so_ff <= side_ff[QW];
      end
   end

   assign out_valid = vo_ff;
   assign tx        = tx_ff;
   assign ty        = ty_ff;
   assign out_side  = so_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pdp_distort.sv -----
// Projection, bounds checks and radial distortion (Horner stages) of one point.
`default_nettype none

module pdp_distort #(
   parameter int IMAGE_WIDTH  = pdp_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = pdp_pkg::DEF_IMAGE_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic signed [31:0]         tx,
   input  logic signed [31:0]         ty,
   input  pdp_pkg::pdp_side_type      in_side,
   input  logic [63:0]                focal_lengths,
   input  logic [63:0]                optical_center,
   input  logic [63:0]                radial_coeffs,
   output logic                       out_valid,
   output pdp_pkg::pdp_outcome_type   out_outcome,
   output logic [11:0]                out_column,
   output logic [11:0]                out_row,
   output logic [30:0]                out_depth
);

   localparam int PW = pdp_pkg::PW;
   localparam logic signed [49:0] U_LIMIT  = 50'(IMAGE_WIDTH * 65536);
   localparam logic signed [49:0] V_LIMIT  = 50'(IMAGE_HEIGHT * 65536);
   localparam logic signed [47:0] UD_LIMIT = 48'(IMAGE_WIDTH * 65536);
   localparam logic signed [47:0] VD_LIMIT = 48'(IMAGE_HEIGHT * 65536);

   // Stage D1: projection products, squared ratios, depth clamp
   logic                 v1_ff;
   logic signed [63:0]   pu_ff;
   logic signed [63:0]   pv_ff;
   logic [63:0]          sqx_ff;
   logic [63:0]          sqy_ff;
   logic                 behind1_ff;
   logic [30:0]          depth1_ff;
   logic [31:0]          ax;
   logic [31:0]          ay;
   logic [30:0]          depth_in;

   assign ax = tx[31] ? 32'(-tx) : tx;
   assign ay = ty[31] ? 32'(-ty) : ty;
   assign depth_in = (in_side.z[pdp_pkg::CW-1:31] != '0) ? 31'h7FFF_FFFF : in_side.z[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         pu_ff      <= 64'(tx) * $signed({32'b0, focal_lengths[63:32]});
         pv_ff      <= 64'(ty) * $signed({32'b0, focal_lengths[31:0]});
         sqx_ff     <= 64'(ax) * 64'(ax);
         sqy_ff     <= 64'(ay) * 64'(ay);
         behind1_ff <= in_side.behind;
         depth1_ff  <= depth_in;
      end
   end

   // Stage D2: pixel position, first bounds check, r2, Horner seed
   logic signed [49:0]       u_w;
   logic signed [49:0]       v_w;
   logic [64:0]              sq_sum;
   logic [48:0]              sq_sh;
   logic                     inside_pre;
   pdp_pkg::pdp_dist_type    d2_in;
   logic signed [15:0]       k4;

   assign u_w    = 50'(signed'(pu_ff[63:16])) + $signed({18'b0, optical_center[63:32]});
   assign v_w    = 50'(signed'(pv_ff[63:16])) + $signed({18'b0, optical_center[31:0]});
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sq_sh  = sq_sum[64:16];
   assign inside_pre = (u_w >= 0) && (u_w < U_LIMIT) && (v_w >= 0) && (v_w < V_LIMIT);
   assign k4     = signed'(radial_coeffs[15:0]);

   always_comb begin
      d2_in.u     = u_w[PW-1:0];
      d2_in.v     = v_w[PW-1:0];
      d2_in.r2    = (sq_sh[48:32] != '0) ? 32'hFFFF_FFFF : sq_sh[31:0];
      d2_in.depth = depth1_ff;
      if (behind1_ff)       d2_in.outcome = pdp_pkg::OUT_BEHIND;
      else if (!inside_pre) d2_in.outcome = pdp_pkg::OUT_OUTSIDE_PRE;
      else                  d2_in.outcome = pdp_pkg::OUT_HIT;
   end

   logic                   va_ff  [0:4];
   logic signed [31:0]     acc_ff [0:4];
   pdp_pkg::pdp_dist_type  da_ff  [0:4];
   logic                   vm_ff  [0:3];
   logic signed [63:0]     m_ff   [0:3];
   pdp_pkg::pdp_dist_type  dm_ff  [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff[0] <= 1'b0;
      end else if (adv) begin
         va_ff[0] <= v1_ff;
      end
      if (adv) begin
         da_ff[0]  <= d2_in;
         acc_ff[0] <= {{12{k4[15]}}, k4, 4'b0};
      end
   end

   // Horner steps for k3, k2, k1, then the final 1 + r2*acc
   for (genvar j = 0; j < 4; j++) begin : g_horner
      logic signed [48:0] addend;
      logic signed [48:0] t;
      logic signed [31:0] t_sat;

      if (j < 3) begin : g_coef
         logic signed [15:0] k;
         assign k      = signed'(radial_coeffs[16*(j+1) +: 16]);
         assign addend = 49'(k) * 49'sd16;
      end else begin : g_one
         assign addend = 49'sd65536;
      end

      assign t = 49'(signed'(m_ff[j][63:16])) + addend;
      assign t_sat = (t > 49'sh0_7FFF_FFFF)  ? 32'sh7FFF_FFFF :
                     (t < -49'sh0_8000_0000) ? 32'sh8000_0000 : t[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vm_ff[j]   <= 1'b0;
            va_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vm_ff[j]   <= va_ff[j];
            va_ff[j+1] <= vm_ff[j];
         end
         if (adv) begin
            m_ff[j]     <= 64'(acc_ff[j]) * $signed({32'b0, da_ff[j].r2});
            dm_ff[j]    <= da_ff[j];
            acc_ff[j+1] <= t_sat;
            da_ff[j+1]  <= dm_ff[j];
         end
      end
   end

   // Stage E1: distortion products
   logic                   ve_ff;
   logic signed [63:0]     pud_ff;
   logic signed [63:0]     pvd_ff;
   pdp_pkg::pdp_dist_type  de_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= va_ff[4];
      end
      if (adv) begin
         pud_ff <= 64'(acc_ff[4]) * $signed({36'b0, da_ff[4].u});
         pvd_ff <= 64'(acc_ff[4]) * $signed({36'b0, da_ff[4].v});
         de_ff  <= da_ff[4];
      end
   end

   // Stage E2: second bounds check and result register
   logic signed [47:0]        ud_w;
   logic signed [47:0]        vd_w;
   logic                      inside_post;
   pdp_pkg::pdp_outcome_type  fin;
   logic                      vo_ff;
   pdp_pkg::pdp_outcome_type  oc_ff;
   logic [11:0]               col_ff;
   logic [11:0]               row_ff;
   logic [30:0]               dep_ff;

   assign ud_w = signed'(pud_ff[63:16]);
   assign vd_w = signed'(pvd_ff[63:16]);
   assign inside_post = (ud_w >= 0) && (ud_w < UD_LIMIT) && (vd_w >= 0) && (vd_w < VD_LIMIT);
   assign fin = (de_ff.outcome == pdp_pkg::OUT_HIT && !inside_post) ?
                pdp_pkg::OUT_OUTSIDE_POST : de_ff.outcome;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= ve_ff;
      end
      if (adv) begin
         oc_ff  <= fin;
         col_ff <= (fin == pdp_pkg::OUT_HIT) ? ud_w[27:16] : '0;
         row_ff <= (fin == pdp_pkg::OUT_HIT) ? vd_w[27:16] : '0;
         dep_ff <= (fin == pdp_pkg::OUT_HIT) ? de_ff.depth : '0;
      end
   end

   assign out_valid   = vo_ff;
   assign out_outcome = oc_ff;
   assign out_column  = col_ff;
   assign out_row     = row_ff;
   assign out_depth   = dep_ff;

endmodule

`default_nettype wire

// ----- rtl/core/point_to_depth_pixel_projection.sv -----
// Top level: configuration registers, pipeline flow control and stage wiring.
//
// Projects one world point (req_point_x/y/z, signed Q16.16) per transaction
// into a camera pixel with radial distortion. The request channel and the
// response channel are valid/ready; csr_write_enable writes csr_wdata into
// the register picked by csr_index, with no read-back.
// A request passes through 48 register stages to its response: 2 transform
// stages, 34 divider stages (one quotient bit each, plus entry and
// saturation), 2 projection stages, 8 Horner stages and 2 output stages.
// Throughput is one point per cycle; the whole pipeline moves together.
// When the receiver stalls with a response waiting, every stage holds and
// req_ready drops; bubbles are squeezed only at the output register.
// Reset clears all stage valid bits and loads the identity rotation with
// zero translation, focal lengths, optical center and coefficients.
// rsp_outcome: 0 hit, 1 behind camera, 2 outside before distortion,
// 3 outside after distortion; pixel and depth fields are 0 unless a hit.
`default_nettype none

module point_to_depth_pixel_projection #(
   parameter int IMAGE_WIDTH  = pdp_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = pdp_pkg::DEF_IMAGE_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_outcome,
   output logic [11:0]         rsp_pixel_column,
   output logic [11:0]         rsp_pixel_row,
   output logic [30:0]         rsp_depth_value,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);

   logic [62:0]         rot_x_ff;
   logic [62:0]         rot_y_ff;
   logic [62:0]         rot_z_ff;
   logic [63:0]         shift_xy_ff;
   logic signed [31:0]  shift_z_ff;
   logic [63:0]         focal_ff;
   logic [63:0]         center_ff;
   logic [63:0]         radial_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff    <= pdp_pkg::ROT_X_RESET;
         rot_y_ff    <= pdp_pkg::ROT_Y_RESET;
         rot_z_ff    <= pdp_pkg::ROT_Z_RESET;
         shift_xy_ff <= '0;
         shift_z_ff  <= '0;
         focal_ff    <= '0;
         center_ff   <= '0;
         radial_ff   <= '0;
      end else if (csr_write_enable) begin
         case (pdp_pkg::pdp_csr_type'(csr_index))
            pdp_pkg::CSR_ROT_X:    rot_x_ff    <= csr_wdata[62:0];
            pdp_pkg::CSR_ROT_Y:    rot_y_ff    <= csr_wdata[62:0];
            pdp_pkg::CSR_ROT_Z:    rot_z_ff    <= csr_wdata[62:0];
            pdp_pkg::CSR_SHIFT_XY: shift_xy_ff <= csr_wdata;
            pdp_pkg::CSR_SHIFT_Z:  shift_z_ff  <= signed'(csr_wdata[31:0]);
            pdp_pkg::CSR_FOCAL:    focal_ff    <= csr_wdata;
            pdp_pkg::CSR_CENTER:   center_ff   <= csr_wdata;
            pdp_pkg::CSR_RADIAL:   radial_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Global advance: the pipeline moves unless a response is stuck
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic                              t_valid;
   logic signed [pdp_pkg::CW-1:0]     cam_x;
   logic signed [pdp_pkg::CW-1:0]     cam_y;
   logic signed [pdp_pkg::CW-1:0]     cam_z;
   logic                              d_valid;
   logic signed [31:0]                tx;
   logic signed [31:0]                ty;
   pdp_pkg::pdp_side_type             side;
   pdp_pkg::pdp_outcome_type          outcome;

   pdp_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .px        (req_point_x),
      .py        (req_point_y),
      .pz        (req_point_z),
      .rot_x     (rot_x_ff),
      .rot_y     (rot_y_ff),
      .rot_z     (rot_z_ff),
      .shift_xy  (shift_xy_ff),
      .shift_z   (shift_z_ff),
      .out_valid (t_valid),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z)
   );

   pdp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t_valid),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z),
      .out_valid (d_valid),
      .tx        (tx),
      .ty        (ty),
      .out_side  (side)
   );

   pdp_distort #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_distort (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (d_valid),
      .tx             (tx),
      .ty             (ty),
      .in_side        (side),
      .focal_lengths  (focal_ff),
      .optical_center (center_ff),
      .radial_coeffs  (radial_ff),
      .out_valid      (rsp_valid),
      .out_outcome    (outcome),
      .out_column     (rsp_pixel_column),
      .out_row        (rsp_pixel_row),
      .out_depth      (rsp_depth_value)
   );

   assign rsp_outcome = outcome;

`ifndef SYNTHESIS
   // Misses carry zero pixel and depth fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != pdp_pkg::OUT_HIT |->
         rsp_pixel_column == '0 && rsp_pixel_row == '0 && rsp_depth_value == '0)
      else $error("miss with nonzero fields");

   // A hit lies in front of the camera
   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == pdp_pkg::OUT_HIT |-> rsp_depth_value != '0)
      else $error("hit with zero depth");

   // A hit lies within the image
   a_hit_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == pdp_pkg::OUT_HIT |->
         {1'b0, rsp_pixel_column} < 13'(IMAGE_WIDTH) &&
         {1'b0, rsp_pixel_row} < 13'(IMAGE_HEIGHT))
      else $error("hit outside image");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_point_to_depth_pixel_projection.sv -----
// Testbench for the point-to-depth-pixel projection block.
`timescale 1ns / 1ps

module tb_point_to_depth_pixel_projection;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;
   localparam longint SAT_LO     = -64'sd2147483648;
   localparam longint SAT_HI     = 64'sd2147483647;
   localparam longint ONE_M      = 64'sd65536;

   typedef struct {
      pdp_pkg::pdp_outcome_type  outcome;
      logic [11:0]               column;
      logic [11:0]               row;
      logic [30:0]               depth;
   } pixel_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_outcome;
   logic [11:0]        rsp_pixel_column;
   logic [11:0]        rsp_pixel_row;
   logic [30:0]        rsp_depth_value;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   // Local copy of the camera registers, indexed by register code
   logic [63:0]      camera_regs [8];
   pixel_result_type pending_pixels [$];
   int               fail_count = 0;
   bit               idle_on = 1'b1;
   int               rx_hold = 0;
   int               stall_count = 0;

   point_to_depth_pixel_projection u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_outcome(rsp_outcome), .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row(rsp_pixel_row), .rsp_depth_value(rsp_depth_value),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------- projection predictor ----------------
   function automatic longint sign_ext(longint unsigned v, int w);
      longint unsigned mask;
      mask = (64'd1 << w) - 64'd1;
      v &= mask;
      if ((v >> (w - 1)) != 0) return longint'(v) - longint'(64'd1 << w);
      return longint'(v);
   endfunction

   // floor(a * b / 2^s)
   function automatic longint floor_mul_shift(longint a, longint unsigned b, int s);
      longint unsigned mag;
      longint unsigned prod;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      prod = mag * b;
      if (a >= 0) return longint'(prod >> s);
      return -longint'((prod + ((64'd1 << s) - 64'd1)) >> s);
   endfunction

   function automatic longint clamp32(longint v);
      if (v < SAT_LO) return SAT_LO;
      if (v > SAT_HI) return SAT_HI;
      return v;
   endfunction

   function automatic longint camera_axis(logic [63:0] row, longint px, longint py,
                                          longint pz, longint shift);
      longint sum;
      sum = sign_ext(row >> 42, 21) * px + sign_ext(row >> 21, 21) * py
          + sign_ext(row, 21) * pz;
      return floor_mul_shift(sum, 64'd1, 19) + shift;
   endfunction

   function automatic bit in_image(longint u, longint v);
      return u >= 0 && u < longint'(pdp_pkg::DEF_IMAGE_WIDTH) * ONE_M
          && v >= 0 && v < longint'(pdp_pkg::DEF_IMAGE_HEIGHT) * ONE_M;
   endfunction

   function automatic pixel_result_type project_point(logic [31:0] wx, logic [31:0] wy,
                                                      logic [31:0] wz);
      pixel_result_type res;
      longint px, py, pz, cx, cy, cz, tx, ty, u, v, acc, factor, ud, vd;
      longint unsigned ax, ay, r2;
      logic [63:0] radial;
      res = '{pdp_pkg::OUT_HIT, 12'd0, 12'd0, 31'd0};
      px = sign_ext(wx, 32);
      py = sign_ext(wy, 32);
      pz = sign_ext(wz, 32);
      cx = camera_axis(camera_regs[pdp_pkg::CSR_ROT_X], px, py, pz,
                       sign_ext(camera_regs[pdp_pkg::CSR_SHIFT_XY] >> 32, 32));
      cy = camera_axis(camera_regs[pdp_pkg::CSR_ROT_Y], px, py, pz,
                       sign_ext(camera_regs[pdp_pkg::CSR_SHIFT_XY], 32));
      cz = camera_axis(camera_regs[pdp_pkg::CSR_ROT_Z], px, py, pz,
                       sign_ext(camera_regs[pdp_pkg::CSR_SHIFT_Z], 32));
      if (cz <= 0) begin
         res.outcome = pdp_pkg::OUT_BEHIND;
         return res;
      end
      tx = clamp32((cx * ONE_M) / cz);
      ty = clamp32((cy * ONE_M) / cz);
      u = floor_mul_shift(tx, camera_regs[pdp_pkg::CSR_FOCAL] >> 32, 16)
        + longint'(camera_regs[pdp_pkg::CSR_CENTER] >> 32);
      v = floor_mul_shift(ty, camera_regs[pdp_pkg::CSR_FOCAL] & 64'hFFFF_FFFF, 16)
        + longint'(camera_regs[pdp_pkg::CSR_CENTER] & 64'hFFFF_FFFF);
      if (!in_image(u, v)) begin
         res.outcome = pdp_pkg::OUT_OUTSIDE_PRE;
         return res;
      end
      ax = (tx < 0) ? longint'(-tx) : longint'(tx);
      ay = (ty < 0) ? longint'(-ty) : longint'(ty);
      r2 = (ax * ax + ay * ay) >> 16;
      if (r2 > 64'hFFFF_FFFF) r2 = 64'hFFFF_FFFF;
      // Horner evaluation, k4 first
      radial = camera_regs[pdp_pkg::CSR_RADIAL];
      acc = sign_ext(radial, 16) * 16;
      for (int i = 1; i <= 3; i++)
         acc = clamp32(sign_ext(radial >> (16 * i), 16) * 16
                       + floor_mul_shift(acc, r2, 16));
      factor = clamp32(ONE_M + floor_mul_shift(acc, r2, 16));
      ud = floor_mul_shift(factor, longint'(u), 16);
      vd = floor_mul_shift(factor, longint'(v), 16);
      if (!in_image(ud, vd)) begin
         res.outcome = pdp_pkg::OUT_OUTSIDE_POST;
         return res;
      end
      res.column = 12'((ud >> 16) & 64'hFFF);
      res.row    = 12'((vd >> 16) & 64'hFFF);
      res.depth  = (cz > SAT_HI) ? 31'h7FFF_FFFF : 31'(cz);
      return res;
   endfunction

   // ---------------- drivers ----------------
   // Write every register from the local copy; block must be idle
   task automatic load_camera_regs();
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_wdata        <= camera_regs[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_reg(pdp_pkg::pdp_csr_type idx, logic [63:0] value);
      if (idx == pdp_pkg::CSR_ROT_X || idx == pdp_pkg::CSR_ROT_Y ||
          idx == pdp_pkg::CSR_ROT_Z)
         value[63] = 1'b0;
      else if (idx == pdp_pkg::CSR_SHIFT_Z)
         value[63:32] = '0;
      camera_regs[idx] = value;
   endtask

   // Drop the request and wait until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Offer one point and wait for the transaction
   task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
      int gap;
      pixel_result_type want;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      want = project_point(wx, wy, wz);
      req_point_x <= wx;
      req_point_y <= wy;
      req_point_z <= wz;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(want);
      @(negedge clock);
   endtask

   // Mostly a point in front of the camera, with |x| and |y| up to 3/4 of z; else fully random
   task automatic send_random_point();
      logic [31:0] wz;
      longint zr, span;
      if ($urandom_range(0, 4) == 0) begin
         send_point($urandom, $urandom, $urandom);
      end else begin
         zr = $urandom_range(32768, 20 * 65536);
         span = zr * 3 / 4;
         wz = 32'(zr);
         send_point(32'(longint'($urandom_range(0, 32'(2 * span))) - span),
                    32'(longint'($urandom_range(0, 32'(2 * span))) - span), wz);
      end
   endtask

   // Rotation row near a unit axis, or fully random
   function automatic logic [63:0] random_rot_row(int axis, bit wild);
      logic [63:0] row;
      longint e;
      if (wild) return {1'b0, 31'($urandom), $urandom};
      row = '0;
      for (int c = 0; c < 3; c++) begin
         e = (c == axis ? 524288 : 0) + longint'($urandom_range(0, 65536)) - 32768;
         row |= (64'(e) & 64'h1F_FFFF) << (42 - 21 * c);
      end
      return row;
   endfunction

   task automatic randomize_camera(bit wild);
      logic [15:0] k [4];
      set_reg(pdp_pkg::CSR_ROT_X, random_rot_row(0, wild));
      set_reg(pdp_pkg::CSR_ROT_Y, random_rot_row(1, wild));
      set_reg(pdp_pkg::CSR_ROT_Z, random_rot_row(2, wild));
      set_reg(pdp_pkg::CSR_SHIFT_XY, {32'($urandom_range(0, 131072) - 65536),
                                      32'($urandom_range(0, 131072) - 65536)});
      set_reg(pdp_pkg::CSR_SHIFT_Z, 64'($urandom_range(0, 65536)));
      set_reg(pdp_pkg::CSR_FOCAL, {32'($urandom_range(200, 800)) << 16,
                                   32'($urandom_range(200, 800)) << 16});
      set_reg(pdp_pkg::CSR_CENTER, {32'($urandom_range(280, 360)) << 16,
                                    32'($urandom_range(200, 280)) << 16});
      for (int i = 0; i < 4; i++) k[i] = 16'($urandom_range(0, 800) - 400);
      set_reg(pdp_pkg::CSR_RADIAL, wild ? {$urandom, $urandom} : {k[0], k[1], k[2], k[3]});
   endtask

   task automatic use_pinhole_camera();
      set_reg(pdp_pkg::CSR_ROT_X, 64'(pdp_pkg::ROT_X_RESET));
      set_reg(pdp_pkg::CSR_ROT_Y, 64'(pdp_pkg::ROT_Y_RESET));
      set_reg(pdp_pkg::CSR_ROT_Z, 64'(pdp_pkg::ROT_Z_RESET));
      set_reg(pdp_pkg::CSR_SHIFT_XY, 64'd0);
      set_reg(pdp_pkg::CSR_SHIFT_Z, 64'd0);
      set_reg(pdp_pkg::CSR_FOCAL, {32'd500 << 16, 32'd500 << 16});
      set_reg(pdp_pkg::CSR_CENTER, {32'd320 << 16, 32'd240 << 16});
      set_reg(pdp_pkg::CSR_RADIAL, {16'sd40, -16'sd20, 16'sd8, -16'sd2});
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      send_point(32'd0, 32'd0, 32'h0001_0000);
      send_point(32'h0002_0000, -32'sh0001_0000, 32'h0004_0000);
      send_point(32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_directed_points();
      wait_idle();
      use_pinhole_camera();
      load_camera_regs();
      send_point(32'd0, 32'd0, 32'h0002_0000);             // on axis
      send_point(32'h0001_0000, 32'h0000_8000, 32'h0003_0000);
      send_point(32'd0, 32'd0, -32'sh0001_0000);           // behind camera
      send_point(32'd0, 32'd0, 32'd0);                     // z at zero
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001); // tiny operands, ratio -1.0
      send_point(32'h0100_0000, 32'd0, 32'h0001_0000);     // outside before
      send_point(32'h0000_8000, 32'h0000_6000, 32'h0001_0000); // near corner
      wait_idle();
      // Zero focal: points project to the center before distortion; ratios may saturate
      set_reg(pdp_pkg::CSR_FOCAL, 64'd0);
      set_reg(pdp_pkg::CSR_RADIAL, 64'h7FFF_7FFF_7FFF_7FFF);
      load_camera_regs();
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
      send_point(32'h0000_1000, 32'h0000_1000, 32'h0001_0000);
      send_point(32'd0, 32'd0, 32'h0001_0000);
      wait_idle();
      set_reg(pdp_pkg::CSR_RADIAL, 64'h8000_8000_8000_8000);
      load_camera_regs();
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
      send_point(32'h0000_4000, 32'h0000_4000, 32'h0001_0000);
      wait_idle();
      // Deep point: depth above the 31-bit range
      set_reg(pdp_pkg::CSR_RADIAL, 64'd0);
      set_reg(pdp_pkg::CSR_SHIFT_Z, 64'h7FFF_FFFF);
      load_camera_regs();
      send_point(32'd0, 32'd0, 32'h7FFF_FFFF);
      send_point(32'd0, 32'd0, 32'h0000_0001);
      wait_idle();
      // All-ones and all-zero registers
      for (int i = 0; i < 8; i++) set_reg(pdp_pkg::pdp_csr_type'(i), '1);
      load_camera_regs();
      send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();
      for (int i = 0; i < 8; i++) set_reg(pdp_pkg::pdp_csr_type'(i), '0);
      load_camera_regs();
      send_point(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
   endtask

   task automatic test_random_cameras();
      for (int s = 0; s < 6; s++) begin
         wait_idle();
         if (s == 0) use_pinhole_camera(); else randomize_camera(s == 5);
         load_camera_regs();
         idle_on = (s % 3) != 1;
         for (int n = 0; n < 180; n++) send_random_point();
      end
      idle_on = 1'b1;
   endtask

   // Receiver holds off while points keep coming, then a full drain pause
   task automatic test_backpressure();
      wait_idle();
      use_pinhole_camera();
      load_camera_regs();
      idle_on = 1'b0;
      rx_hold = 400;
      for (int n = 0; n < 120; n++) send_random_point();
      idle_on = 1'b1;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
      for (int n = 0; n < 40; n++) send_random_point();
   endtask

   // ---------------- result side ----------------
   initial begin : response_ready_driver
      int gap;
      @(negedge clock);
      forever begin
         if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_hold) @(negedge clock);
            rx_hold = 0;
         end else begin
            gap = idle_on ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      pixel_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected response: outcome %0d", rsp_outcome);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
               fail_count++;
            end
            if (rsp_pixel_column !== want.column) begin
               $error("pixel_column: expected %0d, got %0d", want.column, rsp_pixel_column);
               fail_count++;
            end
            if (rsp_pixel_row !== want.row) begin
               $error("pixel_row: expected %0d, got %0d", want.row, rsp_pixel_row);
               fail_count++;
            end
            if (rsp_depth_value !== want.depth) begin
               $error("depth_value: expected %0d, got %0d", want.depth, rsp_depth_value);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : test_sequence
      camera_regs[pdp_pkg::CSR_ROT_X]    = 64'(pdp_pkg::ROT_X_RESET);
      camera_regs[pdp_pkg::CSR_ROT_Y]    = 64'(pdp_pkg::ROT_Y_RESET);
      camera_regs[pdp_pkg::CSR_ROT_Z]    = 64'(pdp_pkg::ROT_Z_RESET);
      camera_regs[pdp_pkg::CSR_SHIFT_XY] = '0;
      camera_regs[pdp_pkg::CSR_SHIFT_Z]  = '0;
      camera_regs[pdp_pkg::CSR_FOCAL]    = '0;
      camera_regs[pdp_pkg::CSR_CENTER]   = '0;
      camera_regs[pdp_pkg::CSR_RADIAL]   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_directed_points();
      test_random_cameras();
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/pdp_pkg.sv
rtl/core/pdp_transform.sv
rtl/core/pdp_divider.sv
rtl/core/pdp_distort.sv
rtl/core/point_to_depth_pixel_projection.sv
tb/sv/tb_point_to_depth_pixel_projection.sv
